// ===== rtl/two_wire_handshake_link_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the two-wire handshake link
// Shared property wrappers used by the link's checker.
// ---------------------------------------------------------------------------
`ifndef TWO_WIRE_HANDSHAKE_LINK_MACROS_SVH
`define TWO_WIRE_HANDSHAKE_LINK_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define TWHL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("two_wire_handshake_link: implication failed");

// Next-cycle implication, switched off while reset is held.
`define TWHL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("two_wire_handshake_link: next-cycle check failed");

// Checks what the cycle after a reset edge must show.
`define TWHL_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("two_wire_handshake_link: reset check failed");

`endif

// ===== rtl/twhl_pkg.sv =====
// ---------------------------------------------------------------------------
// twhl_pkg
// Types and constants shared by the two-wire handshake link.
// ---------------------------------------------------------------------------
package twhl_pkg;

  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [2:0]       cmd_t;
  typedef logic [7:0]       byte_t;
  typedef logic [1:0]       lines_t;
  typedef logic [1:0]       stat_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Command codes.
  localparam cmd_t CMD_TICK    = 3'd0;
  localparam cmd_t CMD_SEND    = 3'd1;
  localparam cmd_t CMD_RECV    = 3'd2;
  localparam cmd_t CMD_RELEASE = 3'd3;
  localparam cmd_t CMD_PROBE   = 3'd4;

  // Completion status codes.
  localparam stat_t STAT_OK       = 2'd0;
  localparam stat_t STAT_WR_TMO   = 2'd1;
  localparam stat_t STAT_RD_TMO   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_TIMEOUT = 2'd2;

  // Drive patterns: bit1 red, bit0 white, 1 means released.
  localparam lines_t DRIVE_RELEASED   = 2'b11;
  localparam lines_t DRIVE_PULL_WHITE = 2'b10;
  localparam lines_t DRIVE_PULL_RED   = 2'b01;

  // Sensed line masks: bit0 red, bit1 white.
  localparam lines_t SENSE_RED   = 2'b01;
  localparam lines_t SENSE_WHITE = 2'b10;
  localparam lines_t SENSE_BOTH  = 2'b11;

  localparam cnt_t CNT_MAX = '1;

  typedef struct packed {
    cnt_t timeout_ticks;
    cnt_t delay_ticks;
    cnt_t probe_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    lines_t lines_out;
    byte_t  rx_byte;
    logic   done_res;
    stat_t  status;
    logic   transfer_done;
    logic   busy_res;
    logic   rx_pending;
  } res_t;

endpackage

// ===== rtl/twhl_in_if.sv =====
// ---------------------------------------------------------------------------
// twhl_in_if
// Input channel: one sampling tick with an optional command per transfer.
// ---------------------------------------------------------------------------
interface twhl_in_if import twhl_pkg::*; ();
  logic   valid;
  logic   ready;
  cmd_t   cmd;
  byte_t  tx_byte;
  logic   last_of_transfer;
  lines_t lines_in;

  modport source (output valid, output cmd, output tx_byte, output last_of_transfer,
                  output lines_in, input ready);
  modport sink   (input valid, input cmd, input tx_byte, input last_of_transfer,
                  input lines_in, output ready);
endinterface

// ===== rtl/twhl_out_if.sv =====
// ---------------------------------------------------------------------------
// twhl_out_if
// Result channel: drive levels and command status for each tick.
// ---------------------------------------------------------------------------
interface twhl_out_if import twhl_pkg::*; ();
  logic   valid;
  logic   ready;
  lines_t lines_out;
  byte_t  rx_byte;
  logic   done_res;
  stat_t  status;
  logic   transfer_done;
  logic   busy_res;
  logic   rx_pending;

  modport source (output valid, output lines_out, output rx_byte, output done_res,
                  output status, output transfer_done, output busy_res,
                  output rx_pending, input ready);
  modport sink   (input valid, input lines_out, input rx_byte, input done_res,
                  input status, input transfer_done, input busy_res,
                  input rx_pending, output ready);
endinterface

// ===== rtl/twhl_cfg.sv =====
// ---------------------------------------------------------------------------
// twhl_cfg
// Configuration registers: handshake timeouts and inter-bit delay.
// ---------------------------------------------------------------------------
module twhl_cfg import twhl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks       <= 16'd15;
      cfg_r.delay_ticks         <= 16'd10;
      cfg_r.probe_timeout_ticks <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT:       cfg_r.timeout_ticks       <= cfg_wdata;
        REG_DELAY:         cfg_r.delay_ticks         <= cfg_wdata;
        REG_PROBE_TIMEOUT: cfg_r.probe_timeout_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/twhl_core.sv =====
// ---------------------------------------------------------------------------
// twhl_core
// Handshake sequencer: advances one tick per accepted item and registers
// the tick's result for the output channel.
// ---------------------------------------------------------------------------
module twhl_core import twhl_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   in_valid,
  output logic   in_ready,
  input  cmd_t   in_cmd,
  input  byte_t  in_tx_byte,
  input  logic   in_last,
  input  lines_t in_lines,
  output logic   out_valid,
  input  logic   out_ready,
  output res_t   out_res
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_ACK_LOW, PH_REL_HIGH, PH_RX_START, PH_RX_ACK, PH_GAP, PH_RELEASE
  } phase_t;

  typedef enum logic [1:0] {OP_SEND, OP_RECV, OP_RELEASE, OP_PROBE} op_t;

  phase_t     phase_r, phase_nxt;
  op_t        op_r, op_nxt;
  byte_t      shift_r, shift_nxt;
  logic [2:0] bit_cnt_r, bit_cnt_nxt;
  cnt_t       wait_cnt_r, wait_cnt_nxt;
  cnt_t       gap_cnt_r, gap_cnt_nxt;
  lines_t     drive_r, drive_nxt;
  logic       last_r, last_nxt;
  logic       out_valid_r, out_valid_nxt;
  res_t       res_r, res_nxt;

  logic       accept;
  logic       fin;
  stat_t      fin_stat;
  cnt_t       wait_inc;
  cnt_t       gap_inc;
  cnt_t       wait_limit;
  stat_t      wait_err;
  logic       wait_expired;
  lines_t     ack_mask;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Shared pieces of the handshake wait: saturating count, limit and error.
  assign wait_inc     = (wait_cnt_r != CNT_MAX) ? wait_cnt_r + 1'b1 : wait_cnt_r;
  assign gap_inc      = (gap_cnt_r != CNT_MAX) ? gap_cnt_r + 1'b1 : gap_cnt_r;
  assign wait_limit   = (op_r == OP_PROBE) ? cfg.probe_timeout_ticks : cfg.timeout_ticks;
  assign wait_err     = (op_r == OP_RECV) ? STAT_RD_TMO :
                        (op_r == OP_RELEASE) ? STAT_OK : STAT_WR_TMO;
  assign wait_expired = (wait_inc >= wait_limit);
  assign ack_mask     = shift_r[0] ? SENSE_RED : SENSE_WHITE;

  always_comb begin
    phase_nxt    = phase_r;
    op_nxt       = op_r;
    shift_nxt    = shift_r;
    bit_cnt_nxt  = bit_cnt_r;
    wait_cnt_nxt = wait_cnt_r;
    gap_cnt_nxt  = gap_cnt_r;
    drive_nxt    = drive_r;
    last_nxt     = last_r;
    fin          = 1'b0;
    fin_stat     = STAT_OK;

    case (phase_r)
      PH_IDLE: begin
        if (in_cmd inside {CMD_SEND, CMD_RECV, CMD_RELEASE, CMD_PROBE}) begin
          bit_cnt_nxt  = '0;
          wait_cnt_nxt = '0;
          case (in_cmd)
            CMD_SEND: begin
              op_nxt    = OP_SEND;
              last_nxt  = in_last;
              shift_nxt = in_tx_byte;
              drive_nxt = in_tx_byte[0] ? DRIVE_PULL_WHITE : DRIVE_PULL_RED;
              phase_nxt = PH_ACK_LOW;
            end
            CMD_RECV: begin
              op_nxt    = OP_RECV;
              last_nxt  = in_last;
              shift_nxt = '0;
              phase_nxt = PH_RX_START;
            end
            CMD_RELEASE: begin
              op_nxt    = OP_RELEASE;
              last_nxt  = 1'b0;
              drive_nxt = DRIVE_RELEASED;
              phase_nxt = PH_RELEASE;
            end
            default: begin
              // Probe sends a one bit and then a zero bit.
              op_nxt    = OP_PROBE;
              last_nxt  = 1'b0;
              shift_nxt = 8'd1;
              drive_nxt = DRIVE_PULL_WHITE;
              phase_nxt = PH_ACK_LOW;
            end
          endcase
        end
      end

      PH_ACK_LOW, PH_REL_HIGH, PH_RX_START, PH_RX_ACK, PH_RELEASE: begin
        logic advance;
        advance = 1'b0;
        case (phase_r)
          PH_ACK_LOW: begin
            if ((in_lines & ack_mask) == '0) begin
              drive_nxt    = DRIVE_RELEASED;
              phase_nxt    = PH_REL_HIGH;
              wait_cnt_nxt = '0;
              advance      = 1'b1;
            end
          end
          PH_REL_HIGH: begin
            if ((in_lines & ack_mask) != '0) begin
              shift_nxt = {1'b0, shift_r[7:1]};
              advance   = 1'b1;
            end
          end
          PH_RX_START: begin
            if (in_lines != SENSE_BOTH) begin
              // Red high with white low carries a one.
              if (in_lines == SENSE_RED) begin
                shift_nxt = {1'b1, shift_r[7:1]};
                drive_nxt = DRIVE_PULL_RED;
              end else begin
                shift_nxt = {1'b0, shift_r[7:1]};
                drive_nxt = DRIVE_PULL_WHITE;
              end
              phase_nxt    = PH_RX_ACK;
              wait_cnt_nxt = '0;
              advance      = 1'b1;
            end
          end
          PH_RX_ACK: begin
            if ((in_lines & ((drive_r == DRIVE_PULL_RED) ? SENSE_WHITE : SENSE_RED)) != '0)
            begin
              drive_nxt = DRIVE_RELEASED;
              advance   = 1'b1;
            end
          end
          default: begin
            drive_nxt = DRIVE_RELEASED;
            if (in_lines == SENSE_BOTH) begin
              phase_nxt = PH_IDLE;
              fin       = 1'b1;
              advance   = 1'b1;
            end
          end
        endcase

        if (!advance) begin
          wait_cnt_nxt = wait_inc;
          if (wait_expired) begin
            phase_nxt = PH_IDLE;
            fin       = 1'b1;
            fin_stat  = wait_err;
          end
        end else if (phase_r == PH_REL_HIGH || phase_r == PH_RX_ACK) begin
          // The bit is complete.
          bit_cnt_nxt = bit_cnt_r + 1'b1;
          if (op_r == OP_PROBE) begin
            if (bit_cnt_nxt == 3'd2) begin
              phase_nxt = PH_IDLE;
              fin       = 1'b1;
            end else begin
              drive_nxt    = shift_nxt[0] ? DRIVE_PULL_WHITE : DRIVE_PULL_RED;
              phase_nxt    = PH_ACK_LOW;
              wait_cnt_nxt = '0;
            end
          end else if (cfg.delay_ticks != '0) begin
            phase_nxt   = PH_GAP;
            gap_cnt_nxt = '0;
          end else if (bit_cnt_nxt == 3'd0) begin
            phase_nxt = PH_IDLE;
            fin       = 1'b1;
          end else if (op_r == OP_SEND) begin
            drive_nxt    = shift_nxt[0] ? DRIVE_PULL_WHITE : DRIVE_PULL_RED;
            phase_nxt    = PH_ACK_LOW;
            wait_cnt_nxt = '0;
          end else begin
            phase_nxt    = PH_RX_START;
            wait_cnt_nxt = '0;
          end
        end
      end

      PH_GAP: begin
        gap_cnt_nxt = gap_inc;
        if (gap_inc >= cfg.delay_ticks) begin
          if (bit_cnt_r == 3'd0) begin
            phase_nxt = PH_IDLE;
            fin       = 1'b1;
          end else if (op_r == OP_SEND) begin
            drive_nxt    = shift_r[0] ? DRIVE_PULL_WHITE : DRIVE_PULL_RED;
            phase_nxt    = PH_ACK_LOW;
            wait_cnt_nxt = '0;
          end else begin
            phase_nxt    = PH_RX_START;
            wait_cnt_nxt = '0;
          end
        end
      end

      default: phase_nxt = PH_IDLE;
    endcase

    res_nxt.lines_out     = drive_nxt;
    res_nxt.rx_byte       = (fin && op_nxt == OP_RECV && fin_stat == STAT_OK) ? shift_nxt : '0;
    res_nxt.done_res      = fin;
    res_nxt.status        = fin ? fin_stat : STAT_OK;
    res_nxt.transfer_done = fin && last_nxt && (op_nxt == OP_SEND || op_nxt == OP_RECV);
    res_nxt.busy_res      = (phase_nxt != PH_IDLE);
    res_nxt.rx_pending    = (in_lines != SENSE_BOTH);

    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      op_r        <= OP_SEND;
      shift_r     <= '0;
      bit_cnt_r   <= '0;
      wait_cnt_r  <= '0;
      gap_cnt_r   <= '0;
      drive_r     <= DRIVE_RELEASED;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        phase_r    <= phase_nxt;
        op_r       <= op_nxt;
        shift_r    <= shift_nxt;
        bit_cnt_r  <= bit_cnt_nxt;
        wait_cnt_r <= wait_cnt_nxt;
        gap_cnt_r  <= gap_cnt_nxt;
        drive_r    <= drive_nxt;
        last_r     <= last_nxt;
        res_r      <= res_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

// ===== rtl/two_wire_handshake_link.sv =====
// ---------------------------------------------------------------------------
// two_wire_handshake_link
// Two-wire handshake serial link, stepped one wire sample per transfer.
// ---------------------------------------------------------------------------
//   Channel   Direction  Carries
//   in_ch     sink       cmd, tx_byte, last_of_transfer, lines_in
//   out_ch    source     lines_out, rx_byte, done_res, status, transfer_done,
//                        busy_res, rx_pending
//   cfg_*     write      timeout_ticks, delay_ticks, probe_timeout_ticks
//
// Each input transfer yields one result transfer in the next cycle; the
// sequencer and result register take one item per cycle unless stalled.
// A result waiting in the output register does not block input as long as
// out_ch.ready is high in the same cycle; a stalled output holds its data.
// Reset is synchronous and active low; it releases both wires, returns the
// sequencer to idle and loads the default register values.
// ---------------------------------------------------------------------------
module two_wire_handshake_link import twhl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  twhl_in_if.sink               in_ch,
  twhl_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;
  res_t res;

  twhl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  twhl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .in_tx_byte(in_ch.tx_byte),
    .in_last   (in_ch.last_of_transfer),
    .in_lines  (in_ch.lines_in),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.lines_out     = res.lines_out;
  assign out_ch.rx_byte       = res.rx_byte;
  assign out_ch.done_res      = res.done_res;
  assign out_ch.status        = res.status;
  assign out_ch.transfer_done = res.transfer_done;
  assign out_ch.busy_res      = res.busy_res;
  assign out_ch.rx_pending    = res.rx_pending;

endmodule

// ===== rtl/twhl_checker.sv =====
// ---------------------------------------------------------------------------
// twhl_checker
// Port-level checks for the two-wire handshake link.
// ---------------------------------------------------------------------------
`include "two_wire_handshake_link_macros.svh"

module twhl_checker import twhl_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input lines_t lines_out,
  input byte_t  rx_byte,
  input logic   done_res,
  input stat_t  status,
  input logic   busy_res
);

  logic [12:0] res_bits;

  assign res_bits = {lines_out, rx_byte, status, done_res};

  `TWHL_ASSERT_RST(a_reset_empty, !out_valid)
  `TWHL_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(res_bits))
  `TWHL_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)
  `TWHL_ASSERT_IMP(a_error_only_done, out_valid && status != STAT_OK, done_res && rx_byte == '0)
  `TWHL_ASSERT_IMP(a_done_not_busy, out_valid && done_res, !busy_res)

endmodule

bind two_wire_handshake_link twhl_checker u_twhl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .lines_out (out_ch.lines_out),
  .rx_byte   (out_ch.rx_byte),
  .done_res  (out_ch.done_res),
  .status    (out_ch.status),
  .busy_res  (out_ch.busy_res)
);
